FILE: rtl/scba_pkg.sv
// shared types, constants and status codes of the size class block allocator
// depends on nothing; every other rtl file imports it
`default_nettype none

package scba_pkg;

	// pool geometry
	localparam int BLOCKS_PER_CLASS = 256;
	localparam int NUM_CLASSES      = 4;
	localparam int CLS_W            = 2;
	localparam int MIN_BLOCK        = 32;
	localparam int MAX_REQ          = 256;

	// port field widths
	localparam int CMD_W  = 1;
	localparam int SIZE_W = 16;
	localparam int OFF_W  = 17;
	localparam int STS_W  = 3;
	localparam int USED_W = 17;

	// free map is kept as words of WORD_W block flags
	localparam int WORD_W          = 16;
	localparam int BIT_W           = $clog2(WORD_W);
	localparam int WORDS_PER_CLASS = (BLOCKS_PER_CLASS + WORD_W - 1) / WORD_W;
	localparam int WIDX_W          = (WORDS_PER_CLASS > 1) ? $clog2(WORDS_PER_CLASS) : 1;
	localparam int BLK_W           = WIDX_W + BIT_W;
	localparam int MEM_ADDR_W      = CLS_W + WIDX_W;
	localparam int MEM_DEPTH       = NUM_CLASSES * (1 << WIDX_W);
	localparam int LAST_BITS       = BLOCKS_PER_CLASS - (WORDS_PER_CLASS - 1) * WORD_W;
	localparam logic [WORD_W-1:0] LAST_MASK =
		WORD_W'((33'd1 << LAST_BITS) - 33'd1);

	// byte offsets inside the pool
	localparam int POOL_W = $clog2(BLOCKS_PER_CLASS * MIN_BLOCK * 16);
	localparam int CMP_W  = (POOL_W > OFF_W) ? POOL_W : OFF_W;
	localparam logic [CMP_W-1:0] BASE_1   = CMP_W'(BLOCKS_PER_CLASS * MIN_BLOCK * 1);
	localparam logic [CMP_W-1:0] BASE_2   = CMP_W'(BLOCKS_PER_CLASS * MIN_BLOCK * 3);
	localparam logic [CMP_W-1:0] BASE_3   = CMP_W'(BLOCKS_PER_CLASS * MIN_BLOCK * 7);
	localparam logic [CMP_W-1:0] POOL_END = CMP_W'(BLOCKS_PER_CLASS * MIN_BLOCK * 15);

	// request codes
	localparam logic [CMD_W-1:0] CMD_ALLOC = 1'b0;
	localparam logic [CMD_W-1:0] CMD_FREE  = 1'b1;

	// result status codes
	localparam logic [STS_W-1:0] STS_OK        = 3'd0;
	localparam logic [STS_W-1:0] STS_EXHAUSTED = 3'd1;
	localparam logic [STS_W-1:0] STS_TOO_LARGE = 3'd2;
	localparam logic [STS_W-1:0] STS_BAD_ADDR  = 3'd3;
	localparam logic [STS_W-1:0] STS_DBL_FREE  = 3'd4;

	// controller to datapath commands
	typedef struct packed {
		logic capture;
		logic look;
		logic commit;
	} ctrl_cmd_t;

endpackage

`default_nettype wire

FILE: rtl/scba_if.sv
// request and response channel interfaces of the allocator
// depends on scba_pkg for field widths
`default_nettype none

interface scba_req_if;
	import scba_pkg::*;

	logic              valid;
	logic              ready;
	logic [CMD_W-1:0]  command;
	logic [SIZE_W-1:0] request_size;
	logic [OFF_W-1:0]  free_offset;

	modport source (output valid, output command, output request_size, output free_offset,
		input ready);
	modport sink (input valid, input command, input request_size, input free_offset,
		output ready);
endinterface

interface scba_rsp_if;
	import scba_pkg::*;

	logic              valid;
	logic              ready;
	logic [STS_W-1:0]  status;
	logic [OFF_W-1:0]  block_offset;
	logic [CLS_W-1:0]  size_class;
	logic [USED_W-1:0] bytes_in_use;

	modport source (output valid, output status, output block_offset, output size_class,
		output bytes_in_use, input ready);
	modport sink (input valid, input status, input block_offset, input size_class,
		input bytes_in_use, output ready);
endinterface

`default_nettype wire

FILE: rtl/scba_ctrl.sv
// sequencing state machine of the allocator: accept, look up, commit
// depends on scba_pkg for the command struct
`default_nettype none

module scba_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	output logic                  out_valid,
	input  logic                  out_ready,
	output scba_pkg::ctrl_cmd_t   cmd
);
	import scba_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE   = 3'b001,
		ST_LOOK   = 3'b010,
		ST_UPDATE = 3'b100
	} state_t;

	state_t state_q;
	state_t state_nxt;
	logic   out_valid_q;
	logic   slot_free;

	assign slot_free   = !out_valid_q || out_ready;
	assign in_ready    = (state_q == ST_IDLE);
	assign out_valid   = out_valid_q;
	assign cmd.capture = in_valid && in_ready;
	assign cmd.look    = (state_q == ST_LOOK);
	assign cmd.commit  = (state_q == ST_UPDATE) && slot_free;

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (cmd.capture) state_nxt = ST_LOOK;
			end
			ST_LOOK: begin
				state_nxt = ST_UPDATE;
			end
			ST_UPDATE: begin
				if (slot_free) state_nxt = ST_IDLE;
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

FILE: rtl/scba_dp.sv
// allocator datapath: request decode, free map words, class summaries, byte count
// depends on scba_pkg for geometry, codes and the command struct
`default_nettype none

module scba_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  scba_pkg::ctrl_cmd_t           cmd,
	input  logic [scba_pkg::CMD_W-1:0]    command,
	input  logic [scba_pkg::SIZE_W-1:0]   request_size,
	input  logic [scba_pkg::OFF_W-1:0]    free_offset,
	output logic [scba_pkg::STS_W-1:0]    status,
	output logic [scba_pkg::OFF_W-1:0]    block_offset,
	output logic [scba_pkg::CLS_W-1:0]    size_class,
	output logic [scba_pkg::USED_W-1:0]   bytes_in_use
);
	import scba_pkg::*;

	// free flags, one bit per block, 1 = free
	logic [WORD_W-1:0] mem [MEM_DEPTH];
	// word written since reset; an unwritten word reads as all free
	logic [MEM_DEPTH-1:0] wv_q;
	// class summary: word still holds a free block
	logic [NUM_CLASSES-1:0][WORDS_PER_CLASS-1:0] sum_q;
	logic [USED_W-1:0] used_q;

	// decoded request
	logic [CMD_W-1:0] cmd_s1;
	logic             too_big_s1;
	logic             bad_s1;
	logic [CLS_W-1:0] cls_s1;
	logic [BLK_W-1:0] blk_s1;
	logic [OFF_W-1:0] off_s1;

	// looked-up word
	logic [WORD_W-1:0] rd_s2;
	logic              wv_s2;
	logic [WIDX_W-1:0] widx_s2;
	logic              exh_s2;

	// result register
	logic [STS_W-1:0]  status_q;
	logic [OFF_W-1:0]  block_offset_q;
	logic [CLS_W-1:0]  size_class_q;
	logic [USED_W-1:0] bytes_q;

	// decode
	logic [CLS_W-1:0] a_cls;
	logic [CLS_W-1:0] f_cls;
	logic [CMP_W-1:0] off_x;
	logic [CMP_W-1:0] f_base;
	logic [CMP_W-1:0] rel;
	logic             misalign;
	logic [BLK_W-1:0] f_blk;

	always_comb begin
		if (request_size <= SIZE_W'(MIN_BLOCK)) begin
			a_cls = 2'd0;
		end else if (request_size <= SIZE_W'(MIN_BLOCK * 2)) begin
			a_cls = 2'd1;
		end else if (request_size <= SIZE_W'(MIN_BLOCK * 4)) begin
			a_cls = 2'd2;
		end else begin
			a_cls = 2'd3;
		end

		off_x = CMP_W'(free_offset);
		if (off_x >= BASE_3) begin
			f_cls  = 2'd3;
			f_base = BASE_3;
		end else if (off_x >= BASE_2) begin
			f_cls  = 2'd2;
			f_base = BASE_2;
		end else if (off_x >= BASE_1) begin
			f_cls  = 2'd1;
			f_base = BASE_1;
		end else begin
			f_cls  = 2'd0;
			f_base = '0;
		end
		rel = off_x - f_base;

		case (f_cls)
			2'd0: begin
				misalign = |rel[4:0];
				f_blk    = BLK_W'(rel >> 5);
			end
			2'd1: begin
				misalign = |rel[5:0];
				f_blk    = BLK_W'(rel >> 6);
			end
			2'd2: begin
				misalign = |rel[6:0];
				f_blk    = BLK_W'(rel >> 7);
			end
			default: begin
				misalign = |rel[7:0];
				f_blk    = BLK_W'(rel >> 8);
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			cmd_s1     <= command;
			too_big_s1 <= (request_size > SIZE_W'(MAX_REQ));
			bad_s1     <= (off_x >= POOL_END) || misalign;
			cls_s1     <= (command == CMD_FREE) ? f_cls : a_cls;
			blk_s1     <= f_blk;
			off_s1     <= free_offset;
		end
	end

	// look-up: first word of the class with a free block, or the word to free
	logic [WORDS_PER_CLASS-1:0] sum_row;
	logic [WIDX_W-1:0]          sum_pe;
	logic [WIDX_W-1:0]          look_widx;
	logic [MEM_ADDR_W-1:0]      look_addr;

	always_comb begin
		sum_row = sum_q[cls_s1];
		sum_pe  = '0;
		for (int i = WORDS_PER_CLASS - 1; i >= 0; i--) begin
			if (sum_row[i]) sum_pe = WIDX_W'(i);
		end
		look_widx = (cmd_s1 == CMD_FREE) ? blk_s1[BLK_W-1:BIT_W] : sum_pe;
		look_addr = {cls_s1, look_widx};
	end

	always_ff @(posedge clk) begin
		if (cmd.look) begin
			rd_s2   <= mem[look_addr];
			wv_s2   <= wv_q[look_addr];
			widx_s2 <= look_widx;
			exh_s2  <= !(|sum_row);
		end
	end

	// update
	logic [WORD_W-1:0]     word;
	logic [BIT_W-1:0]      a_bit;
	logic [BIT_W-1:0]      sel_bit;
	logic [WORD_W-1:0]     onehot;
	logic [BLK_W-1:0]      blk_sel;
	logic [CMP_W-1:0]      a_off;
	logic [USED_W-1:0]     cls_bytes;
	logic [WORD_W-1:0]     new_word;
	logic                  upd;
	logic [STS_W-1:0]      sts_nxt;
	logic [OFF_W-1:0]      off_nxt;
	logic [CLS_W-1:0]      cls_nxt;
	logic [USED_W-1:0]     used_nxt;
	logic [MEM_ADDR_W-1:0] wr_addr;

	always_comb begin
		if (wv_s2) begin
			word = rd_s2;
		end else if (widx_s2 == WIDX_W'(WORDS_PER_CLASS - 1)) begin
			word = LAST_MASK;
		end else begin
			word = '1;
		end

		a_bit = '0;
		for (int i = WORD_W - 1; i >= 0; i--) begin
			if (word[i]) a_bit = BIT_W'(i);
		end
		sel_bit = (cmd_s1 == CMD_FREE) ? blk_s1[BIT_W-1:0] : a_bit;
		onehot  = WORD_W'(1) << sel_bit;
		blk_sel = {widx_s2, sel_bit};
		cls_bytes = USED_W'(MIN_BLOCK) << cls_s1;

		case (cls_s1)
			2'd0:    a_off = CMP_W'(blk_sel) << 5;
			2'd1:    a_off = BASE_1 + (CMP_W'(blk_sel) << 6);
			2'd2:    a_off = BASE_2 + (CMP_W'(blk_sel) << 7);
			default: a_off = BASE_3 + (CMP_W'(blk_sel) << 8);
		endcase

		upd      = 1'b0;
		new_word = word;
		sts_nxt  = STS_OK;
		off_nxt  = '0;
		cls_nxt  = cls_s1;
		used_nxt = used_q;
		if (cmd_s1 == CMD_ALLOC) begin
			if (too_big_s1) begin
				sts_nxt = STS_TOO_LARGE;
				cls_nxt = '0;
			end else if (exh_s2) begin
				sts_nxt = STS_EXHAUSTED;
			end else begin
				upd      = 1'b1;
				new_word = word & ~onehot;
				off_nxt  = a_off[OFF_W-1:0];
				used_nxt = used_q + cls_bytes;
			end
		end else begin
			if (bad_s1) begin
				sts_nxt = STS_BAD_ADDR;
				cls_nxt = '0;
			end else if (|(word & onehot)) begin
				sts_nxt = STS_DBL_FREE;
			end else begin
				upd      = 1'b1;
				new_word = word | onehot;
				off_nxt  = off_s1;
				used_nxt = used_q - cls_bytes;
			end
		end
		wr_addr = {cls_s1, widx_s2};
	end

	always_ff @(posedge clk) begin
		if (cmd.commit && upd) begin
			mem[wr_addr] <= new_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wv_q   <= '0;
			sum_q  <= '1;
			used_q <= '0;
		end else if (cmd.commit && upd) begin
			wv_q[wr_addr]           <= 1'b1;
			sum_q[cls_s1][widx_s2]  <= |new_word;
			used_q                  <= used_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			status_q       <= sts_nxt;
			block_offset_q <= off_nxt;
			size_class_q   <= cls_nxt;
			bytes_q        <= used_nxt;
		end
	end

	assign status       = status_q;
	assign block_offset = block_offset_q;
	assign size_class   = size_class_q;
	assign bytes_in_use = bytes_q;

endmodule

`default_nettype wire

FILE: rtl/size_class_block_allocator.sv
// top level of the size class block allocator: controller plus datapath
// depends on scba_pkg, scba_if, scba_ctrl and scba_dp
//
// usage
//   req channel: a word carries command (alloc or free), request_size and
//   free_offset; it is taken when req.valid and req.ready are both high
//   rsp channel: one word per request with status, block_offset, size_class
//   and bytes_in_use after the request
//   an alloc takes the lowest free block of the smallest class that fits,
//   a free checks range, block alignment and double free
// request sequence
//   per request: accept, look up the free map word, then update and load the
//   response register, valid the cycle after that; a new request is taken only
//   in idle. The free map lives in a memory of 16-block words, so each request
//   waits on its registered word read before the read-modify-write can complete
// reset
//   every block free and the byte count zero at once; unwritten words read as
//   all free, so no clearing sweep is run
// stall
//   a finished response waits in its register while the next request is
//   already taken; a request meeting a held response waits in its update step
`default_nettype none

module size_class_block_allocator (
	input logic        clk,
	input logic        arst_n,
	scba_req_if.sink   req,
	scba_rsp_if.source rsp
);
	import scba_pkg::*;

	ctrl_cmd_t cmd;

	// sequencing: idle/accept, look-up, commit
	scba_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.cmd       (cmd)
	);

	// decode, free map, summaries and response register
	scba_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.command      (req.command),
		.request_size (req.request_size),
		.free_offset  (req.free_offset),
		.status       (rsp.status),
		.block_offset (rsp.block_offset),
		.size_class   (rsp.size_class),
		.bytes_in_use (rsp.bytes_in_use)
	);

	// only one step of the sequence is active in any cycle
	a_one_step: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.capture, cmd.look, cmd.commit}))
		else $error("more than one controller step active");

	// every accepted word has a response waiting once its look-up and update steps are done
	a_rsp_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |-> ##3 rsp.valid)
		else $error("no response after accepted request");

	// error responses carry no block offset
	a_err_offset: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.status != STS_OK) |-> (rsp.block_offset == '0))
		else $error("error response with nonzero offset");

	// oversize and bad-address responses report class zero
	a_err_class: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && (rsp.status == STS_TOO_LARGE || rsp.status == STS_BAD_ADDR))
		|-> (rsp.size_class == '0))
		else $error("class reported on range error");

endmodule

`default_nettype wire
